// File: sv/bus_decoder_with_rom_ram_banking_assert.svh
// Assertion macros for the bus decoder checker.
// Used by bdrb_checker.sv only; no other dependencies.
`ifndef BUS_DECODER_WITH_ROM_RAM_BANKING_ASSERT_SVH
`define BUS_DECODER_WITH_ROM_RAM_BANKING_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BDRB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BDRB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/bdrb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bus decoder with bank switching.
// No dependencies; imported by every module of the block.
package bdrb_pkg;

  typedef enum logic [2:0] {
    TGT_INTERNAL = 3'd0,
    TGT_ROM      = 3'd1,
    TGT_RAM      = 3'd2,
    TGT_JOYPAD   = 3'd3,
    TGT_IGNORED  = 3'd4
  } target_t;

  localparam logic [15:0] ADDR_ECHO_LO  = 16'hE000;
  localparam logic [15:0] ADDR_ECHO_HI  = 16'hFDFF;
  localparam logic [15:0] ECHO_OFFSET   = 16'h2000;
  localparam logic [15:0] ADDR_JOYPAD   = 16'hFF00;
  localparam logic [15:0] ADDR_DIVIDER  = 16'hFF04;
  localparam logic [15:0] ADDR_IRQ_FLAG = 16'hFF0F;
  localparam logic [15:0] ADDR_SCANLINE = 16'hFF44;
  localparam logic [15:0] ADDR_DMA      = 16'hFF46;
  localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;
  localparam logic [7:0]  IRQ_FORCE     = 8'hE0;

  // Top three address bits of the cartridge and RAM windows
  localparam logic [2:0] WIN_RAM_EN   = 3'b000;
  localparam logic [2:0] WIN_ROM_LOW  = 3'b001;
  localparam logic [2:0] WIN_UPPER    = 3'b010;
  localparam logic [2:0] WIN_MODE     = 3'b011;
  localparam logic [2:0] WIN_EXT_RAM  = 3'b101;

  localparam logic [7:0] CART_MBC1_MAX  = 8'd3;
  localparam logic [7:0] CART_MODE_LO   = 8'd2;

  localparam int PHYS_W = 21;

  typedef struct packed {
    logic        req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    target_t             target;
    logic [PHYS_W-1:0]   phys_addr;
    logic                write_enable;
    logic [7:0]          write_value;
    logic                dma_start;
    logic [7:0]          dma_page;
  } result_t;

  typedef struct packed {
    logic [6:0] rom_bank;
    logic [6:0] rom_read_bank;
    logic [1:0] ram_bank;
    logic       bank_mode;
  } bank_state_t;

endpackage

// File: sv/bus_decoder_with_rom_ram_banking.sv
`timescale 1ns / 1ps
// Bus decoder with bank-switching cartridge registers.
// An accepted access passes through the input register and then the result register.
// Throughput: one access per cycle while m_tready is not holding a result; the only path is
// the decode logic between the input register and the result register.
// Reset (synchronous, active high) empties both registers, clears cart_type,
// and sets the banks to ROM read bank 1, everything else zero.
module bus_decoder_with_rom_ram_banking
  import bdrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,   // cart_type
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // address[15:0], write_data[23:16]
  input  logic        s_tuser,    // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,    // phys_addr[20:0], write_enable[21], write_value[29:22],
                                  // dma_start[30], dma_page[38:31], zero[39]
  output logic [2:0]  m_tuser     // target
);

  logic [7:0]  cart_type;
  logic        in_vld;
  item_t       in_item;
  result_t     out_res;
  result_t     res;
  bank_state_t state;
  bank_state_t state_next;
  logic        adv;
  logic        take;

  // refuse transfers while reset is held
  assign cfg_ready = !rst;
  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = !rst && (!in_vld || adv);
  assign take      = s_tvalid && s_tready;

  bdrb_decode u_decode (
    .item       (in_item),
    .cart_type  (cart_type),
    .state      (state),
    .res        (res),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cart_type <= 8'd0;
    end else if (cfg_valid) begin
      cart_type <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (take) begin
      in_vld <= 1'b1;
    end else if (adv) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item.req_type   <= s_tuser;
      in_item.address    <= s_tdata[15:0];
      in_item.write_data <= s_tdata[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid            <= 1'b0;
      state.rom_bank      <= 7'd0;
      state.rom_read_bank <= 7'd1;
      state.ram_bank      <= 2'd0;
      state.bank_mode     <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_vld;
      // advance the bank registers only when the access is consumed
      if (in_vld) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_vld) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.target;
  assign m_tdata = {1'b0, out_res.dma_page, out_res.dma_start, out_res.write_value,
                    out_res.write_enable, out_res.phys_addr};

endmodule

// File: sv/bdrb_decode.sv
`timescale 1ns / 1ps
// Address decode and bank register update for one bus access.
// Depends on bdrb_pkg; purely combinational.
module bdrb_decode
  import bdrb_pkg::*;
(
  input  item_t       item,
  input  logic [7:0]  cart_type,
  input  bank_state_t state,
  output result_t     res,
  output bank_state_t state_next
);

  logic [15:0] a;
  logic [7:0]  d;
  logic [2:0]  win;
  logic        banking;
  logic        mode_ok;
  logic        is_echo;
  logic [15:0] echo_addr;
  logic [4:0]  low_bank;

  assign a         = item.address;
  assign d         = item.write_data;
  assign win       = a[15:13];
  assign banking   = (cart_type != 8'd0) && (cart_type <= CART_MBC1_MAX);
  assign mode_ok   = (cart_type == CART_MODE_LO) || (cart_type == CART_MBC1_MAX);
  assign is_echo   = (a >= ADDR_ECHO_LO) && (a <= ADDR_ECHO_HI);
  assign echo_addr = a - ECHO_OFFSET;
  // bank zero on the low register selects bank one
  assign low_bank  = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];

  always_comb begin
    res.target       = TGT_INTERNAL;
    res.phys_addr    = {5'd0, a};
    res.write_enable = 1'b0;
    res.write_value  = 8'd0;
    res.dma_start    = 1'b0;
    res.dma_page     = 8'd0;
    state_next       = state;

    if (!item.req_type) begin
      if (a[15:14] == 2'b00) begin
        res.target = TGT_ROM;
      end else if (a[15:14] == 2'b01) begin
        res.target    = TGT_ROM;
        res.phys_addr = {state.rom_read_bank, a[13:0]};
      end else if (win == WIN_EXT_RAM) begin
        res.target    = TGT_RAM;
        res.phys_addr = {6'd0, state.ram_bank, a[12:0]};
      end else if (is_echo) begin
        res.phys_addr = {5'd0, echo_addr};
      end else if (a == ADDR_JOYPAD) begin
        res.target = TGT_JOYPAD;
      end
    end else if (a[15] == 1'b0) begin
      // cartridge register writes touch no memory
      res.target    = TGT_IGNORED;
      res.phys_addr = '0;
      case (win)
        WIN_ROM_LOW: begin
          if (banking) begin
            state_next.rom_bank      = {state.rom_bank[6:5], low_bank};
            state_next.rom_read_bank = {state.rom_bank[6:5], low_bank};
          end
        end
        WIN_UPPER: begin
          if (banking) begin
            if (state.bank_mode) begin
              state_next.ram_bank = d[1:0];
            end else begin
              state_next.rom_bank      = {d[1:0], state.rom_bank[4:0]};
              state_next.rom_read_bank = {d[1:0], state.rom_bank[4:0]};
            end
          end
        end
        WIN_MODE: begin
          if (mode_ok) begin
            state_next.bank_mode = d[0];
          end
        end
        default: begin
          // RAM enable writes are dropped
        end
      endcase
    end else if (win == WIN_EXT_RAM) begin
      res.target       = TGT_RAM;
      res.phys_addr    = {6'd0, state.ram_bank, a[12:0]};
      res.write_enable = 1'b1;
      res.write_value  = d;
    end else if (is_echo) begin
      res.phys_addr    = {5'd0, echo_addr};
      res.write_enable = 1'b1;
      res.write_value  = d;
    end else if ((a == ADDR_DIVIDER) || (a == ADDR_SCANLINE)) begin
      res.write_enable = 1'b1;
    end else if (a == ADDR_JOYPAD) begin
      res.target       = TGT_JOYPAD;
      res.write_enable = 1'b1;
      res.write_value  = d;
    end else if (a == ADDR_IRQ_FLAG) begin
      res.write_enable = 1'b1;
      res.write_value  = d | IRQ_FORCE;
    end else if (a == ADDR_DMA) begin
      res.write_enable = 1'b1;
      res.write_value  = d;
      res.dma_start    = 1'b1;
      res.dma_page     = d;
    end else if (a == ADDR_BOOT_OFF) begin
      res.target    = TGT_IGNORED;
      res.phys_addr = '0;
    end else begin
      res.write_enable = 1'b1;
      res.write_value  = d;
    end
  end

endmodule

// File: sv/bdrb_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the bus decoder, bound to the top level.
// Depends on bdrb_pkg and bus_decoder_with_rom_ram_banking_assert.svh.
`include "bus_decoder_with_rom_ram_banking_assert.svh"

module bdrb_checker
  import bdrb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [2:0]  m_tuser
);

  `BDRB_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `BDRB_ASSERT_NOW(a_zero_fill, clk, rst, m_tvalid, (m_tdata[21] || (m_tdata[29:22] == 8'd0)) && (m_tdata[30] || (m_tdata[38:31] == 8'd0)), "unused write or page byte not zero")
  `BDRB_ASSERT_NOW(a_ignored_quiet, clk, rst, m_tvalid && (m_tuser == TGT_IGNORED), (m_tdata[20:0] == 21'd0) && !m_tdata[21] && !m_tdata[30], "ignored access carries an address or write")
  `BDRB_ASSERT_NOW(a_rom_readonly, clk, rst, m_tvalid && (m_tuser == TGT_ROM), !m_tdata[21] && !m_tdata[30], "write directed at cartridge rom")

endmodule

bind bus_decoder_with_rom_ram_banking bdrb_checker u_bdrb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
